FILE: hdl/dlbc_pkg.sv
package dlbc_pkg;

    // Bitrate word width (bits per second values)
    localparam int BR_W = 28;

    localparam int MAGIC_W    = 32;
    localparam int LOSS_PM_W  = 10;
    localparam int CONG_W     = 2;
    localparam int OVH_W      = 15;
    localparam int LAVG_W     = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_BITRATE     = 2'd0,
        REG_MAX_BITRATE     = 2'd1,
        REG_INITIAL_BITRATE = 2'd2,
        REG_EXPECTED_MAGIC  = 2'd3
    } t_cfg_reg;

    // Congestion codes carried in a report
    localparam logic [CONG_W-1:0] CONG_NORMAL  = 2'd0;
    localparam logic [CONG_W-1:0] CONG_OVERUSE = 2'd1;
    localparam logic [CONG_W-1:0] CONG_DRAIN   = 2'd2;

    // Reset values
    localparam logic [BR_W-1:0]    MIN_BITRATE_RST  = BR_W'(1000000);
    localparam logic [BR_W-1:0]    MAX_BITRATE_RST  = BR_W'(20000000);
    localparam logic [BR_W-1:0]    INIT_BITRATE_RST = BR_W'(8000000);
    localparam logic [MAGIC_W-1:0] MAGIC_RST        = '0;
    localparam logic [OVH_W-1:0]   OVERHEAD_INIT    = OVH_W'(6554);

    // Loss handling
    localparam logic [LOSS_PM_W-1:0] LOSS_PM_MAX = LOSS_PM_W'(1000);
    localparam logic [LOSS_PM_W-1:0] LOSS_BAD_PM = LOSS_PM_W'(200);

    // FEC target: 0.02 + 2*loss, saturating at 0.25 once 2p+20 > 250
    localparam int FEC_TBL_LAST = 115;
    localparam logic [OVH_W-1:0] TARGET_MAX = OVH_W'(16384);

    typedef logic [OVH_W-1:0] t_fec_table [0:FEC_TBL_LAST];

    function automatic t_fec_table fec_table_build();
        t_fec_table tbl;
        for (int f = 0; f <= FEC_TBL_LAST; f++) begin
            tbl[f] = OVH_W'((((20 + 2 * f) * 65536) + 500) / 1000);
        end
        return tbl;
    endfunction

    localparam t_fec_table FEC_TARGET_TABLE = fec_table_build();

    // Overhead EMA: x / 10 as (x * M) >> 21, exact for x < 2^18
    localparam int OVH_SUM_W     = 18;
    localparam int DIV10_SHIFT   = 21;
    localparam logic [OVH_SUM_W-1:0] DIV10_RECIP = OVH_SUM_W'(209716);

    // Loss EMA, reduced: (375*old + 16384*p + 312) / 625, x < 2^26
    localparam int LAVG_SUM_W    = 26;
    localparam int DIV625_SHIFT  = 36;
    localparam int DIV625_RCP_W  = 27;
    localparam logic [DIV625_RCP_W-1:0] DIV625_RECIP = DIV625_RCP_W'(109951163);
    localparam int LAVG_PROD_W   = LAVG_SUM_W + DIV625_RCP_W;
    // average * 100 < 65536  <=>  average < 656
    localparam logic [LAVG_W-1:0] LOSS_LOW_LIMIT = LAVG_W'(656);

    // Bitrate cut: floor(4*br / 5) as (4*br * M) >> (BR_W+5)
    localparam int DIV5_SHIFT = BR_W + 5;
    localparam int DIV5_RCP_W = BR_W + 3;
    localparam logic [DIV5_RCP_W-1:0] DIV5_RECIP =
        DIV5_RCP_W'(((64'd1 << DIV5_SHIFT) + 64'd4) / 64'd5);
    localparam int CUT_PROD_W = (BR_W + 2) + DIV5_RCP_W;

    localparam logic [BR_W:0] UP_STEP = (BR_W+1)'(300000);

endpackage

FILE: hdl/delay_loss_bitrate_controller_top.sv
// Each report is registered in the input stage, its result in the result stage.
// Throughput: one report per cycle unless the output stalls; the bitrate, overhead
// and loss-average state closes its loop between input and result registers.
// Reports with a wrong magic word are dropped without a result or state change.
// Reset (i_rst_n low, synchronous) empties both stages, loads the register reset
// values and sets bitrate 8000000, overhead 0.10 and loss average 0.
module delay_loss_bitrate_controller_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [dlbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dlbc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,

    // feedback report channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [dlbc_pkg::MAGIC_W-1:0]     i_magic,
    input  logic [dlbc_pkg::LOSS_PM_W-1:0]   i_loss_permille,
    input  logic [dlbc_pkg::CONG_W-1:0]      i_congestion_state,
    input  logic                             i_keyframe_request,

    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [dlbc_pkg::BR_W-1:0]        o_target_bitrate,
    output logic [dlbc_pkg::OVH_W-1:0]       o_fec_overhead_q16,
    output logic                             o_keyframe_request_out
);

    localparam int BR_W = dlbc_pkg::BR_W;

    // configuration registers; the start bitrate only matters at the moment
    // it is written, so it is loaded straight into the bitrate state
    logic [BR_W-1:0]                r_min_bitrate;
    logic [BR_W-1:0]                r_max_bitrate;
    logic [dlbc_pkg::MAGIC_W-1:0]   r_exp_magic;

    // controller state
    logic [BR_W-1:0]                r_bitrate;
    logic [dlbc_pkg::OVH_W-1:0]     r_overhead;
    logic [dlbc_pkg::LAVG_W-1:0]    r_loss_avg;

    // input stage: loss is saturated and overuse decoded on the way in
    logic                           r_in_valid;
    logic [dlbc_pkg::MAGIC_W-1:0]   r_in_magic;
    logic [dlbc_pkg::LOSS_PM_W-1:0] r_in_loss;
    logic                           r_in_overuse;
    logic                           r_in_key;

    // result stage
    logic                           r_out_valid;
    logic [BR_W-1:0]                r_out_bitrate;
    logic [dlbc_pkg::OVH_W-1:0]     r_out_overhead;
    logic                           r_out_key;

    logic                           in_accept;
    logic                           out_free;
    logic                           magic_ok;
    logic                           advance;
    logic                           update;
    logic [dlbc_pkg::LOSS_PM_W-1:0] loss_sat;
    logic [dlbc_pkg::OVH_W-1:0]     n_overhead;
    logic [dlbc_pkg::LAVG_W-1:0]    n_loss_avg;
    logic [BR_W-1:0]                n_bitrate;
    logic                           avg_low;
    logic                           cut;

    // Result register frees up when empty or when its word leaves this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    assign magic_ok = r_in_magic == r_exp_magic;
    // A dropped report never needs the result register, so it always moves on.
    assign advance  = r_in_valid && (out_free || !magic_ok);
    assign update   = advance && magic_ok;

    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign loss_sat = (i_loss_permille > dlbc_pkg::LOSS_PM_MAX)
                    ? dlbc_pkg::LOSS_PM_MAX : i_loss_permille;

    // Cut on overuse or heavy loss; draining and the unused code act as normal.
    assign cut = r_in_overuse || (r_in_loss > dlbc_pkg::LOSS_BAD_PM);

    dlbc_fec u_fec (
        .i_loss_pm  (r_in_loss),
        .i_overuse  (r_in_overuse),
        .i_overhead (r_overhead),
        .o_overhead (n_overhead)
    );

    // loss average uses the measured loss, not the overuse-forced one
    dlbc_loss u_loss (
        .i_loss_pm (r_in_loss),
        .i_avg     (r_loss_avg),
        .o_avg     (n_loss_avg),
        .o_low     (avg_low)
    );

    dlbc_rate u_rate (
        .i_bitrate (r_bitrate),
        .i_min     (r_min_bitrate),
        .i_max     (r_max_bitrate),
        .i_cut     (cut),
        .i_raise   (avg_low),
        .o_bitrate (n_bitrate)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_magic   <= i_magic;
            r_in_loss    <= loss_sat;
            r_in_overuse <= i_congestion_state == dlbc_pkg::CONG_OVERUSE;
            r_in_key     <= i_keyframe_request;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (update) begin
            r_out_bitrate  <= n_bitrate;
            r_out_overhead <= n_overhead;
            r_out_key      <= r_in_key;
        end
    end

    // configuration and state; writes must come only while idle, so a reload never
    // collides with a report update; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bitrate  <= dlbc_pkg::MIN_BITRATE_RST;
            r_max_bitrate  <= dlbc_pkg::MAX_BITRATE_RST;
            r_exp_magic    <= dlbc_pkg::MAGIC_RST;
            r_bitrate      <= dlbc_pkg::INIT_BITRATE_RST;
            r_overhead     <= dlbc_pkg::OVERHEAD_INIT;
            r_loss_avg     <= '0;
        end else begin
            if (update) begin
                r_bitrate  <= n_bitrate;
                r_overhead <= n_overhead;
                r_loss_avg <= n_loss_avg;
            end
            if (i_cfg_we) begin
                unique case (dlbc_pkg::t_cfg_reg'(i_cfg_index))
                    dlbc_pkg::REG_MIN_BITRATE: begin
                        r_min_bitrate <= i_cfg_wdata[BR_W-1:0];
                    end
                    dlbc_pkg::REG_MAX_BITRATE: begin
                        r_max_bitrate <= i_cfg_wdata[BR_W-1:0];
                    end
                    dlbc_pkg::REG_INITIAL_BITRATE: begin
                        r_bitrate      <= i_cfg_wdata[BR_W-1:0];
                        r_overhead     <= dlbc_pkg::OVERHEAD_INIT;
                        r_loss_avg     <= '0;
                    end
                    dlbc_pkg::REG_EXPECTED_MAGIC: begin
                        r_exp_magic <= i_cfg_wdata[dlbc_pkg::MAGIC_W-1:0];
                    end
                endcase
            end
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_target_bitrate       = r_out_bitrate;
    assign o_fec_overhead_q16     = r_out_overhead;
    assign o_keyframe_request_out = r_out_key;

endmodule

FILE: hdl/dlbc_fec.sv
// FEC overhead EMA: new = (7*old + 3*target + 5) / 10
module dlbc_fec (
    input  logic [dlbc_pkg::LOSS_PM_W-1:0] i_loss_pm,
    input  logic                           i_overuse,
    input  logic [dlbc_pkg::OVH_W-1:0]     i_overhead,
    output logic [dlbc_pkg::OVH_W-1:0]     o_overhead
);

    localparam int PROD_W = 2 * dlbc_pkg::OVH_SUM_W;

    logic [dlbc_pkg::LOSS_PM_W-1:0] fpm;
    logic [dlbc_pkg::OVH_W-1:0]     target;
    logic [dlbc_pkg::OVH_SUM_W-1:0] sum;
    logic [PROD_W-1:0]              prod;
    logic [dlbc_pkg::OVH_W-1:0]     quot;

    assign fpm = i_overuse ? '0 : i_loss_pm;

    always_comb begin
        if (fpm > dlbc_pkg::LOSS_PM_W'(dlbc_pkg::FEC_TBL_LAST)) begin
            target = dlbc_pkg::TARGET_MAX;
        end else begin
            target = dlbc_pkg::FEC_TARGET_TABLE[fpm[6:0]];
        end
    end

    assign sum = dlbc_pkg::OVH_SUM_W'(i_overhead) * dlbc_pkg::OVH_SUM_W'(7)
               + dlbc_pkg::OVH_SUM_W'(target) * dlbc_pkg::OVH_SUM_W'(3)
               + dlbc_pkg::OVH_SUM_W'(5);

    assign prod = PROD_W'(sum) * PROD_W'(dlbc_pkg::DIV10_RECIP);
    assign quot = prod[dlbc_pkg::DIV10_SHIFT +: dlbc_pkg::OVH_W];

    assign o_overhead = (quot > dlbc_pkg::TARGET_MAX) ? dlbc_pkg::TARGET_MAX : quot;

endmodule

FILE: hdl/dlbc_loss.sv
// Loss EMA: 0.6*old + 0.4*loss in Q0.16, rounded half up
module dlbc_loss (
    input  logic [dlbc_pkg::LOSS_PM_W-1:0] i_loss_pm,
    input  logic [dlbc_pkg::LAVG_W-1:0]    i_avg,
    output logic [dlbc_pkg::LAVG_W-1:0]    o_avg,
    output logic                           o_low
);

    localparam int QUOT_W = dlbc_pkg::LAVG_PROD_W - dlbc_pkg::DIV625_SHIFT;

    logic [dlbc_pkg::LAVG_SUM_W-1:0]  sum;
    logic [dlbc_pkg::LAVG_PROD_W-1:0] prod;
    logic [QUOT_W-1:0]                quot;

    assign sum = dlbc_pkg::LAVG_SUM_W'(i_avg) * dlbc_pkg::LAVG_SUM_W'(375)
               + (dlbc_pkg::LAVG_SUM_W'(i_loss_pm) << 14)
               + dlbc_pkg::LAVG_SUM_W'(312);

    assign prod = dlbc_pkg::LAVG_PROD_W'(sum) * dlbc_pkg::LAVG_PROD_W'(dlbc_pkg::DIV625_RECIP);
    assign quot = prod[dlbc_pkg::DIV625_SHIFT +: QUOT_W];

    assign o_avg = (quot > QUOT_W'({dlbc_pkg::LAVG_W{1'b1}}))
                 ? {dlbc_pkg::LAVG_W{1'b1}} : quot[dlbc_pkg::LAVG_W-1:0];
    assign o_low = o_avg < dlbc_pkg::LOSS_LOW_LIMIT;

endmodule

FILE: hdl/dlbc_rate.sv
// Bitrate step: cut to 4/5, raise by a fixed step, or hold; then clamp
module dlbc_rate (
    input  logic [dlbc_pkg::BR_W-1:0] i_bitrate,
    input  logic [dlbc_pkg::BR_W-1:0] i_min,
    input  logic [dlbc_pkg::BR_W-1:0] i_max,
    input  logic                      i_cut,
    input  logic                      i_raise,
    output logic [dlbc_pkg::BR_W-1:0] o_bitrate
);

    localparam int BR_W = dlbc_pkg::BR_W;

    logic [BR_W+1:0]                 x4;
    logic [dlbc_pkg::CUT_PROD_W-1:0] prod;
    logic [BR_W-1:0]                 cut_br;
    logic [BR_W:0]                   step_br;
    logic [BR_W:0]                   lo_br;

    assign x4     = {i_bitrate, 2'b00};
    assign prod   = dlbc_pkg::CUT_PROD_W'(x4)
                  * dlbc_pkg::CUT_PROD_W'(dlbc_pkg::DIV5_RECIP);
    assign cut_br = prod[dlbc_pkg::DIV5_SHIFT +: BR_W];

    always_comb begin
        priority if (i_cut) begin
            step_br = {1'b0, cut_br};
        end else if (i_raise) begin
            step_br = {1'b0, i_bitrate} + dlbc_pkg::UP_STEP;
        end else begin
            step_br = {1'b0, i_bitrate};
        end
        // max clamp last, so an inverted window yields max
        lo_br = (step_br < {1'b0, i_min}) ? {1'b0, i_min} : step_br;
        if (lo_br > {1'b0, i_max}) begin
            o_bitrate = i_max;
        end else begin
            o_bitrate = lo_br[BR_W-1:0];
        end
    end

endmodule

FILE: sim/dlbc_rate_checker.sv
`timescale 1ns / 1ps

module dlbc_rate_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dlbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dlbc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [dlbc_pkg::MAGIC_W-1:0]    i_magic,
    input  logic [dlbc_pkg::LOSS_PM_W-1:0]  i_loss_permille,
    input  logic [dlbc_pkg::CONG_W-1:0]     i_congestion_state,
    input  logic                            i_keyframe_request,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [dlbc_pkg::BR_W-1:0]       i_target_bitrate,
    input  logic [dlbc_pkg::OVH_W-1:0]      i_fec_overhead_q16,
    input  logic                            i_keyframe_request_out,
    output int                              o_fail_count,
    output int                              o_rates_pending,
    output int                              o_rates_checked,
    output int                              o_reports_dropped
);
    import dlbc_pkg::*;

    localparam logic [BR_W-1:0]    RST_MIN_BR  = BR_W'(1000000);
    localparam logic [BR_W-1:0]    RST_MAX_BR  = BR_W'(20000000);
    localparam logic [BR_W-1:0]    RST_INIT_BR = BR_W'(8000000);
    localparam logic [OVH_W-1:0]   RST_OVH     = OVH_W'(6554);
    localparam longint unsigned    PM_CAP      = 1000;
    localparam longint unsigned    PM_BAD      = 200;
    localparam longint unsigned    FEC_CAP     = 16384;
    localparam longint unsigned    AVG_CAP     = 65535;
    localparam longint unsigned    RISE_STEP   = 300000;

    typedef struct packed {
        logic [BR_W-1:0]  bitrate;
        logic [OVH_W-1:0] overhead;
        logic             keyframe;
    } t_rate_word;

    t_rate_word expected_rates[$];

    // predictor copy of the registers and state
    logic [BR_W-1:0]    min_br, max_br;
    logic [MAGIC_W-1:0] magic_ref;
    logic [BR_W-1:0]    cur_br;
    logic [OVH_W-1:0]   ovh;
    logic [LAVG_W-1:0]  loss_avg;

    int fails, checked, dropped;

    initial begin
        fails   = 0;
        checked = 0;
        dropped = 0;
    end

    always @(posedge i_clk) begin
        longint unsigned p, fpm, fec_sum, fec_target, ovh_next, avg, br;
        logic            overuse;
        t_rate_word      got, want;

        if (!i_rst_n) begin
            min_br    = RST_MIN_BR;
            max_br    = RST_MAX_BR;
            magic_ref = '0;
            cur_br    = RST_INIT_BR;
            ovh       = RST_OVH;
            loss_avg  = '0;
            expected_rates.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_MIN_BITRATE: min_br = i_cfg_wdata[BR_W-1:0];
                    REG_MAX_BITRATE: max_br = i_cfg_wdata[BR_W-1:0];
                    REG_INITIAL_BITRATE: begin
                        cur_br   = i_cfg_wdata[BR_W-1:0];
                        ovh      = RST_OVH;
                        loss_avg = '0;
                    end
                    REG_EXPECTED_MAGIC: magic_ref = i_cfg_wdata[MAGIC_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                got = {i_target_bitrate, i_fec_overhead_q16, i_keyframe_request_out};
                if (expected_rates.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word, expected none, got bitrate %0d overhead %0d key %0b",
                             $time, got.bitrate, got.overhead, got.keyframe);
                end else begin
                    want = expected_rates.pop_front();
                    checked++;
                    if (got.bitrate !== want.bitrate) begin
                        fails++;
                        $display("%0t: bitrate expected %0d got %0d",
                                 $time, want.bitrate, got.bitrate);
                    end
                    if (got.overhead !== want.overhead) begin
                        fails++;
                        $display("%0t: fec overhead expected %0d got %0d",
                                 $time, want.overhead, got.overhead);
                    end
                    if (got.keyframe !== want.keyframe) begin
                        fails++;
                        $display("%0t: keyframe expected %0b got %0b",
                                 $time, want.keyframe, got.keyframe);
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_magic != magic_ref) begin
                    dropped++;
                end else begin
                    p       = (i_loss_permille > PM_CAP) ? PM_CAP : i_loss_permille;
                    overuse = (i_congestion_state == CONG_OVERUSE);

                    // FEC target ignores loss under overuse
                    fpm     = overuse ? 0 : p;
                    fec_sum = 2 * fpm + 20;
                    fec_target = (fec_sum > 250) ? FEC_CAP : (fec_sum * 65536 + 500) / 1000;
                    ovh_next = (7 * ovh + 3 * fec_target + 5) / 10;
                    if (ovh_next > FEC_CAP)
                        ovh_next = FEC_CAP;
                    ovh = OVH_W'(ovh_next);

                    // loss EMA always uses measured loss
                    avg = (6000 * loss_avg + 262144 * p + 5000) / 10000;
                    if (avg > AVG_CAP)
                        avg = AVG_CAP;
                    loss_avg = LAVG_W'(avg);

                    br = cur_br;
                    if (overuse || p > PM_BAD)
                        br = (br * 4) / 5;
                    else if (avg * 100 < 65536)
                        br = br + RISE_STEP;
                    if (br < min_br)
                        br = min_br;
                    if (br > max_br)
                        br = max_br;
                    cur_br = BR_W'(br);

                    want = {cur_br, ovh, i_keyframe_request};
                    expected_rates.push_back(want);
                end
            end
        end

        o_fail_count      <= fails;
        o_rates_pending   <= expected_rates.size();
        o_rates_checked   <= checked;
        o_reports_dropped <= dropped;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dlbc_pkg::*;

    // no-progress cycles before the run is declared hung
    localparam int WATCHDOG_LIMIT    = 2000;
    // pipeline is 2 deep; a few spare cycles cover dropped words in flight
    localparam int DRAIN_CYCLES      = 8;
    localparam int HOLD_OFF_CYCLES   = 60;
    localparam int RANDOM_PHASES     = 6;
    localparam int REPORTS_PER_PHASE = 180;

    localparam logic [CONG_W-1:0] CONG_UNUSED = 2'd3;
    localparam logic [BR_W-1:0]   BR_TOP      = '1;

    // loss patterns; runs of clean reports are needed to pull the
    // loss average under 0.01 so the bitrate actually climbs
    typedef enum int {LOSS_CLEAN, LOSS_HEAVY, LOSS_ANY} t_loss_regime;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MIN_BITRATE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [MAGIC_W-1:0]    magic = '0;
    logic [LOSS_PM_W-1:0]  loss_pm = '0;
    logic [CONG_W-1:0]     cong = CONG_NORMAL;
    logic                  key_req = 1'b0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BR_W-1:0]       target_br;
    logic [OVH_W-1:0]      fec_ovh;
    logic                  key_out;

    int fail_count, rates_pending, rates_checked, reports_dropped;

    int           snd_idle_pct = 0;
    int           rcv_idle_pct = 0;
    logic         hold_armed = 1'b0;
    int           reports_sent = 0;
    int           settings_used = 1;
    int           idle_cycles = 0;
    logic [MAGIC_W-1:0] magic_now = '0;   // value last written to the magic register
    t_loss_regime loss_regime = LOSS_CLEAN;
    int           regime_left = 0;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    delay_loss_bitrate_controller_top i_dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_wdata            (cfg_wdata),
        .i_in_valid             (in_valid),
        .o_in_stall             (in_stall),
        .i_magic                (magic),
        .i_loss_permille        (loss_pm),
        .i_congestion_state     (cong),
        .i_keyframe_request     (key_req),
        .o_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .o_target_bitrate       (target_br),
        .o_fec_overhead_q16     (fec_ovh),
        .o_keyframe_request_out (key_out)
    );

    dlbc_rate_checker i_checker (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_wdata            (cfg_wdata),
        .i_in_valid             (in_valid),
        .i_in_stall             (in_stall),
        .i_magic                (magic),
        .i_loss_permille        (loss_pm),
        .i_congestion_state     (cong),
        .i_keyframe_request     (key_req),
        .i_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .i_target_bitrate       (target_br),
        .i_fec_overhead_q16     (fec_ovh),
        .i_keyframe_request_out (key_out),
        .o_fail_count           (fail_count),
        .o_rates_pending        (rates_pending),
        .o_rates_checked        (rates_checked),
        .o_reports_dropped      (reports_dropped)
    );

    // Result side: random stall, plus one long hold-off when armed so the
    // pipeline backs up and the block has to stall the report channel.
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    // Hang detector: counts edges with no word moving on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("delay_loss_bitrate_controller_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one report word and hold it until the block takes it.
    task automatic send_report(input logic [MAGIC_W-1:0] m, input logic [LOSS_PM_W-1:0] pm,
                               input logic [CONG_W-1:0] cs, input logic kf);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        magic    <= m;
        loss_pm  <= pm;
        cong     <= cs;
        key_req  <= kf;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        reports_sent++;
    endtask

    // Register writes only happen with the block drained.
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_EXPECTED_MAGIC)
            magic_now = data;
    endtask

    // Stop offering, wait for every predicted word, then let the pipe empty.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rates_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One random report; returns 1 if it carries the current magic word.
    task automatic send_random_report(output bit counted);
        logic [MAGIC_W-1:0]   m;
        logic [LOSS_PM_W-1:0] pm;
        logic [CONG_W-1:0]    cs;
        int                   pick;

        if (regime_left == 0) begin
            pick        = $urandom_range(99);
            loss_regime = (pick < 45) ? LOSS_CLEAN : (pick < 75) ? LOSS_HEAVY : LOSS_ANY;
            regime_left = $urandom_range(12, 1);
        end
        regime_left--;

        // mostly good magic; the rest is junk or a single flipped bit
        pick = $urandom_range(99);
        if (pick < 88)
            m = magic_now;
        else if (pick < 94)
            m = $urandom;
        else
            m = magic_now ^ (32'd1 << $urandom_range(31));

        case (loss_regime)
            LOSS_CLEAN: pm = LOSS_PM_W'($urandom_range(4));
            LOSS_HEAVY: pm = ($urandom_range(1) != 0) ? LOSS_PM_W'($urandom_range(260, 150))
                                                       : LOSS_PM_W'($urandom_range(1023, 990));
            default:    pm = LOSS_PM_W'($urandom_range(1023));
        endcase

        pick = $urandom_range(99);
        cs = (pick < 60) ? CONG_NORMAL : (pick < 75) ? CONG_OVERUSE :
             (pick < 90) ? CONG_DRAIN : CONG_UNUSED;

        send_report(m, pm, cs, 1'($urandom_range(1)));
        counted = (m == magic_now);
    endtask

    initial begin : stimulus
        int good;
        bit counted;
        logic [BR_W-1:0] pick_br;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, reset register values (magic 0) ----
        snd_idle_pct = 33;
        rcv_idle_pct = 57;
        send_report('0, 10'd0,    CONG_NORMAL,  1'b1);   // zero loss: rise
        send_report('0, 10'd0,    CONG_DRAIN,   1'b0);   // draining acts as normal
        send_report('0, 10'd3,    CONG_UNUSED,  1'b1);   // unused code treated as normal
        send_report('0, 10'd115,  CONG_NORMAL,  1'b0);   // FEC target right at 0.25
        send_report('0, 10'd116,  CONG_NORMAL,  1'b0);   // FEC target saturates
        send_report('0, 10'd200,  CONG_NORMAL,  1'b1);   // loss at the cut threshold: hold
        send_report('0, 10'd201,  CONG_NORMAL,  1'b0);   // just above: cut
        send_report('0, 10'd1000, CONG_NORMAL,  1'b0);
        send_report('0, 10'd1023, CONG_DRAIN,   1'b1);   // loss above 1000 saturates
        send_report('0, 10'd1001, CONG_NORMAL,  1'b0);
        send_report('0, 10'd1000, CONG_OVERUSE, 1'b0);   // overuse: FEC sees zero loss
        send_report('0, 10'd0,    CONG_OVERUSE, 1'b1);
        send_report('1, 10'd0,    CONG_NORMAL,  1'b1);   // wrong magic: dropped
        send_report(32'h1, 10'd500, CONG_OVERUSE, 1'b0); // wrong magic: dropped
        repeat (4) send_report('0, 10'd0, CONG_NORMAL, 1'b0);
        wait_idle();

        // rising past the bitrate width: sum overflows 28 bits, max clamp pulls it back
        write_reg(REG_MIN_BITRATE, '0);
        write_reg(REG_MAX_BITRATE, 32'hFFFF_FFFF);
        write_reg(REG_INITIAL_BITRATE, 32'(BR_TOP - BR_W'(100)));
        write_reg(REG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
        settings_used++;
        send_report('1, 10'd0, CONG_NORMAL, 1'b1);
        wait_idle();

        // inverted window, with the start bitrate above both bounds
        write_reg(REG_MIN_BITRATE, 32'd5000000);
        write_reg(REG_MAX_BITRATE, 32'd2000000);
        write_reg(REG_INITIAL_BITRATE, 32'd30000000);
        settings_used++;
        send_report('1, 10'd0,   CONG_NORMAL,  1'b0);
        send_report('1, 10'd400, CONG_OVERUSE, 1'b1);
        wait_idle();

        // zero-width window at the bottom
        write_reg(REG_MAX_BITRATE, '0);
        write_reg(REG_MIN_BITRATE, '0);
        write_reg(REG_EXPECTED_MAGIC, 32'hA5C3_5A3C);
        settings_used++;
        send_report(32'hA5C3_5A3C, 10'd0, CONG_NORMAL, 1'b1);
        send_report(32'hA5C3_5A3C, 10'd700, CONG_DRAIN, 1'b0);
        wait_idle();

        // ---- random phases, one register setting each ----
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph < 2) begin
                snd_idle_pct = 33;
                rcv_idle_pct = 57;
            end else if (ph < 4) begin
                snd_idle_pct = 57;
                rcv_idle_pct = 33;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            case (ph)
                0: begin   // widest window
                    write_reg(REG_MIN_BITRATE, '0);
                    write_reg(REG_MAX_BITRATE, 32'hFFFF_FFFF);
                    write_reg(REG_INITIAL_BITRATE, $urandom);
                    write_reg(REG_EXPECTED_MAGIC, $urandom);
                end
                1: begin   // anything, window may come out inverted
                    write_reg(REG_MIN_BITRATE, $urandom);
                    write_reg(REG_MAX_BITRATE, $urandom);
                    write_reg(REG_INITIAL_BITRATE, $urandom);
                    write_reg(REG_EXPECTED_MAGIC, $urandom);
                end
                2: begin   // usual window, start below it
                    write_reg(REG_MIN_BITRATE, 32'd1000000);
                    write_reg(REG_MAX_BITRATE, 32'd20000000);
                    write_reg(REG_INITIAL_BITRATE, '0);
                    write_reg(REG_EXPECTED_MAGIC, $urandom);
                end
                3: begin   // min equals max
                    pick_br = BR_W'($urandom);
                    write_reg(REG_MIN_BITRATE, 32'(pick_br));
                    write_reg(REG_MAX_BITRATE, 32'(pick_br));
                    write_reg(REG_INITIAL_BITRATE, $urandom);
                    write_reg(REG_EXPECTED_MAGIC, $urandom);
                end
                4: begin
                    write_reg(REG_MIN_BITRATE, 32'd300000);
                    write_reg(REG_MAX_BITRATE, 32'd12000000);
                    write_reg(REG_INITIAL_BITRATE, 32'd8000000);
                    write_reg(REG_EXPECTED_MAGIC, '0);
                end
                default: begin
                    write_reg(REG_MIN_BITRATE, $urandom_range(2000000));
                    write_reg(REG_MAX_BITRATE, $urandom_range(40000000, 8000000));
                    write_reg(REG_INITIAL_BITRATE, $urandom_range(60000000));
                    write_reg(REG_EXPECTED_MAGIC, $urandom);
                end
            endcase
            settings_used++;

            // long receiver hold-off while reports keep coming back to back
            if (ph == 4)
                hold_armed = 1'b1;

            good = 0;
            while (good < REPORTS_PER_PHASE) begin
                send_random_report(counted);
                if (counted)
                    good++;
            end
            wait_idle();
        end

        $display("Sent %0d feedback reports over %0d register settings, %0d dropped for magic.",
                 reports_sent, settings_used, reports_dropped);
        $display("Checked %0d result words under sender and receiver gaps and a long hold-off.",
                 rates_checked);
        if (fail_count == 0) begin
            $display("delay_loss_bitrate_controller_top: match");
        end else begin
            $display("delay_loss_bitrate_controller_top: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/dlbc_pkg.sv
hdl/dlbc_fec.sv
hdl/dlbc_loss.sv
hdl/dlbc_rate.sv
hdl/delay_loss_bitrate_controller_top.sv
sim/dlbc_rate_checker.sv
sim/tb_top.sv
